@@ src/error_diffusion_dither_quantizer_unit_defines.svh @@
// Assertion macros for the error diffusion dither quantizer.
// Used by the checker module; depends on nothing.
`ifndef ERROR_DIFFUSION_DITHER_QUANTIZER_UNIT_DEFINES_SVH
`define ERROR_DIFFUSION_DITHER_QUANTIZER_UNIT_DEFINES_SVH

// Consequent checked at the same edge as the antecedent.
`define EDQ_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("edq: same-cycle check failed");

// Consequent checked at the edge after the antecedent.
`define EDQ_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("edq: next-cycle check failed");

`endif

@@ src/edq_pkg.sv @@
// Shared constants, types and arithmetic helpers of the error diffusion quantizer.
// No dependencies.
package edq_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int N_CH       = 3;
  localparam int ERR_W      = 11;
  localparam int PIX_W      = 8;
  localparam int WIDTH_W    = 12;
  localparam int DEPTH_W    = 4;
  localparam int MAX_DEPTH  = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam int MEM_W      = ERR_W * N_CH;

  localparam int RESET_WIDTH = 640;
  localparam int RESET_DEPTH = 3;

  // diffused sample v and its error fit in 13 bits signed
  localparam int V_W    = 14;
  localparam int PROD_W = V_W + 3;
  localparam int P_W    = 16;
  localparam int RECIP_W = P_W;

  localparam int ERR_MAX = (2 ** (ERR_W - 1)) - 1;
  localparam int ERR_MIN = -(2 ** (ERR_W - 1));

  // diffusion weights, sixteenths
  localparam int W_RIGHT       = 7;
  localparam int W_BELOW_LEFT  = 3;
  localparam int W_BELOW       = 5;
  localparam int W_BELOW_RIGHT = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_DEPTH = 1'b1;

  typedef logic        [PIX_W-1:0] pix_t;
  typedef logic signed [V_W-1:0]   val_t;
  typedef logic signed [V_W:0]     sum_t;
  typedef logic signed [ERR_W-1:0] err_t;

  typedef struct packed {
    logic [PIX_W-1:0]   levels;
    logic [RECIP_W-1:0] recip;
  } qparam_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_QUANT,
    S_WR_LEFT,
    S_WR_HERE,
    S_DONE
  } state_t;

  localparam sum_t SUM_HI = sum_t'(ERR_MAX);
  localparam sum_t SUM_LO = sum_t'(ERR_MIN);

  // floor(65536 / (2^d - 1)); depth 1 never reaches the divide path
  function automatic logic [RECIP_W-1:0] recip_of(input logic [DEPTH_W-1:0] depth);
    logic [RECIP_W-1:0] r;
    unique case (depth)
      4'd1:    r = 16'hFFFF;
      4'd2:    r = 16'd21845;
      4'd3:    r = 16'd9362;
      4'd4:    r = 16'd4369;
      4'd5:    r = 16'd2114;
      4'd6:    r = 16'd1040;
      4'd7:    r = 16'd516;
      4'd8:    r = 16'd257;
      default: r = 16'd257;
    endcase
    return r;
  endfunction

  // t / 16, rounded half to even
  function automatic val_t rhe16(input logic signed [PROD_W-1:0] t);
    logic signed [PROD_W-1:0] q;
    logic [3:0] r;
    q = t >>> 4;
    r = t[3:0];
    if (r > 4'd8 || (r == 4'd8 && q[0])) begin
      q = q + PROD_W'(1);
    end
    return val_t'(q);
  endfunction

  function automatic err_t sat_err(input sum_t s);
    err_t r;
    if (s > SUM_HI) begin
      r = err_t'(SUM_HI);
    end else if (s < SUM_LO) begin
      r = err_t'(SUM_LO);
    end else begin
      r = err_t'(s);
    end
    return r;
  endfunction

endpackage

@@ src/edq_pix_if.sv @@
// Pixel input channel: valid/ready handshake with blue, green, red samples.
// Depends on edq_pkg.
interface edq_pix_if;
  import edq_pkg::*;

  logic valid;
  logic ready;
  pix_t blue_in;
  pix_t green_in;
  pix_t red_in;
  logic last_in_frame;

  modport source (output valid, blue_in, green_in, red_in, last_in_frame, input ready);
  modport sink   (input valid, blue_in, green_in, red_in, last_in_frame, output ready);
endinterface

@@ src/edq_res_if.sv @@
// Result channel: valid/ready handshake with the quantized samples.
// Depends on edq_pkg.
interface edq_res_if;
  import edq_pkg::*;

  logic valid;
  logic ready;
  pix_t blue_out;
  pix_t green_out;
  pix_t red_out;

  modport source (output valid, blue_out, green_out, red_out, input ready);
  modport sink   (input valid, blue_out, green_out, red_out, output ready);
endinterface

@@ src/edq_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module edq_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 33,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ src/edq_quant.sv @@
// Seven-stage quantizer for all channels: level index by reciprocal divide by 255,
// then level to output sample by per-depth reciprocal. Depends on edq_pkg.
module edq_quant (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  edq_pkg::qparam_t  qp,
  input  edq_pkg::val_t     v [edq_pkg::N_CH],
  output logic              done,
  output edq_pkg::pix_t     q [edq_pkg::N_CH],
  output edq_pkg::val_t     e [edq_pkg::N_CH]
);
  import edq_pkg::*;

  localparam int NST     = 7;
  localparam int MUL_W   = V_W + PIX_W + 1;
  localparam int U_W     = 21;
  localparam int ACC_W   = U_W + 1;
  localparam int Q0_W    = ACC_W - 8;
  localparam int R_W     = U_W + 1;
  localparam int MP_W    = 2 * P_W;
  localparam int Q_BIAS  = 4096;
  localparam int Q_OFFSET = 255 * Q_BIAS;
  localparam int DIV_Q   = 255;
  localparam int HALF_Q  = 128;

  logic [NST-1:0] vld;
  qparam_t qp0;

  val_t               v0  [N_CH];
  logic [U_W-1:0]     u1  [N_CH];
  logic [Q0_W-1:0]    q2  [N_CH];
  val_t               n3  [N_CH];
  logic [P_W-1:0]     p4  [N_CH];
  logic               lo4 [N_CH];
  logic               hi4 [N_CH];
  logic [PIX_W-1:0]   qq5 [N_CH];

  logic signed [MUL_W-1:0] prod1   [N_CH];
  logic [ACC_W-1:0]        acc2    [N_CH];
  logic [R_W-1:0]          r3      [N_CH];
  logic [Q0_W-1:0]         qa3     [N_CH];
  val_t                    n_next  [N_CH];
  logic [P_W-1:0]          p_next  [N_CH];
  logic [MP_W-1:0]         m5      [N_CH];
  logic [P_W-1:0]          r6      [N_CH];
  logic [PIX_W-1:0]        qf6     [N_CH];
  pix_t                    qsel    [N_CH];

  always_comb begin
    for (int k = 0; k < N_CH; k++) begin
      prod1[k] = MUL_W'(v0[k]) * MUL_W'($signed({1'b0, qp0.levels})) + MUL_W'(Q_OFFSET);

      acc2[k] = ACC_W'(u1[k]) + ACC_W'(u1[k] >> 8) + ACC_W'(u1[k] >> 16);

      // remainder of u / 255; the estimate is short by at most one
      r3[k]  = R_W'(u1[k]) - (R_W'(q2[k]) << 8) + R_W'(q2[k]);
      qa3[k] = q2[k];
      if (r3[k] >= R_W'(DIV_Q)) begin
        qa3[k] = q2[k] + Q0_W'(1);
        r3[k]  = r3[k] - R_W'(DIV_Q);
      end
      if (r3[k] >= R_W'(HALF_Q)) begin
        qa3[k] = qa3[k] + Q0_W'(1);
      end
      n_next[k] = val_t'(qa3[k]) - val_t'(Q_BIAS);

      p_next[k] = (P_W'(n3[k][PIX_W-1:0]) << 8) - P_W'(n3[k][PIX_W-1:0]);

      m5[k] = MP_W'(p4[k]) * MP_W'(qp0.recip);

      r6[k]  = p4[k] - P_W'(qq5[k]) * P_W'(qp0.levels);
      qf6[k] = qq5[k] + PIX_W'(r6[k] >= P_W'(qp0.levels));
      if (lo4[k]) begin
        qsel[k] = '0;
      end else if (hi4[k]) begin
        qsel[k] = '1;
      end else begin
        qsel[k] = qf6[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NST-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qp0 <= qp;
    end
    for (int k = 0; k < N_CH; k++) begin
      if (start) begin
        v0[k] <= v[k];
      end
      if (vld[0]) begin
        u1[k] <= prod1[k][U_W-1:0];
      end
      if (vld[1]) begin
        q2[k] <= acc2[k][ACC_W-1:8];
      end
      if (vld[2]) begin
        n3[k] <= n_next[k];
      end
      if (vld[3]) begin
        p4[k]  <= p_next[k];
        lo4[k] <= (n3[k] <= val_t'(0));
        hi4[k] <= (n3[k] >= $signed(V_W'(qp0.levels)));
      end
      if (vld[4]) begin
        qq5[k] <= m5[k][P_W+PIX_W-1:P_W];
      end
      if (vld[5]) begin
        q[k] <= qsel[k];
        e[k] <= v0[k] - val_t'(qsel[k]);
      end
    end
  end

  assign done = vld[NST-1];
endmodule

@@ src/error_diffusion_dither_quantizer_unit.sv @@
// Error diffusion dither quantizer, top level: control sequencer, error state, row memory.
// Depends on edq_pkg, edq_pix_if, edq_res_if, edq_ram, edq_quant.
//
// Takes raster-order pixels and returns one quantized, dithered pixel per input
// transaction, using Floyd-Steinberg weights per channel. Pixels are handled one
// at a time: each accepted pixel goes through the row-memory read, the seven-stage
// quantizer and the write-back of the shares below, with one extra row-memory write
// for the last pixel of a row, and the result register may wait on result.ready
// before the next pixel is accepted. The next pixel's diffused sample depends on
// this pixel's right-hand share. The row memory needs no clearing: the top row of a
// frame ignores what it reads. Configuration is to be written through
// cfg_write/cfg_index/cfg_data only while no pixel is in flight; the block leaves this to the user.
module error_diffusion_dither_quantizer_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [edq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [edq_pkg::CFG_DATA_W-1:0]  cfg_data,
  edq_pix_if.sink                         pixel,
  edq_res_if.source                       result
);
  import edq_pkg::*;

  state_t state, state_next;

  logic [WIDTH_W-1:0] image_width;
  logic [DEPTH_W-1:0] color_depth;
  logic [WIDTH_W-1:0] w_eff;
  logic [DEPTH_W-1:0] d_eff;
  qparam_t            qp;

  logic [COL_W-1:0] column_count;
  logic             first_row;
  logic             last_col;
  logic             last_frame;

  pix_t pix [N_CH];
  val_t rc  [N_CH];
  err_t bp0 [N_CH];
  err_t bp1 [N_CH];

  logic             accept;
  logic             mem_re;
  logic             mem_we;
  logic [COL_W-1:0] mem_waddr;
  logic [MEM_W-1:0] mem_wdata;
  logic [MEM_W-1:0] mem_rdata;
  logic [MEM_W-1:0] wdata_left;
  logic [MEM_W-1:0] wdata_here;

  logic q_start;
  logic q_done;
  val_t vq [N_CH];
  pix_t qo [N_CH];
  val_t eo [N_CH];

  val_t s_right [N_CH];
  val_t s_bl    [N_CH];
  val_t s_below [N_CH];
  val_t s_br    [N_CH];
  err_t bp0_next [N_CH];
  err_t bp1_next [N_CH];

  logic out_valid;
  logic out_free;
  logic out_load;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_W'(RESET_WIDTH);
      color_depth <= DEPTH_W'(RESET_DEPTH);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: image_width <= cfg_data[WIDTH_W-1:0];
        REG_COLOR_DEPTH: color_depth <= cfg_data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (image_width > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (color_depth == '0) begin
      d_eff = DEPTH_W'(1);
    end else if (color_depth > DEPTH_W'(MAX_DEPTH)) begin
      d_eff = DEPTH_W'(MAX_DEPTH);
    end else begin
      d_eff = color_depth;
    end
    qp.levels = PIX_W'(((PIX_W + 1)'(1) << d_eff) - (PIX_W + 1)'(1));
    qp.recip  = recip_of(d_eff);
    last_col  = (WIDTH_W'(column_count) + WIDTH_W'(1)) >= w_eff;
  end

  assign accept   = pixel.valid && pixel.ready;
  assign out_free = !out_valid || result.ready;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (accept) state_next = S_READ;
      S_READ:    state_next = S_QUANT;
      S_QUANT:   if (q_done) state_next = S_WR_LEFT;
      S_WR_LEFT: state_next = last_col ? S_WR_HERE : S_DONE;
      S_WR_HERE: state_next = S_DONE;
      S_DONE:    if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pixel.ready = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = column_count;
    mem_wdata   = wdata_here;
    q_start     = 1'b0;
    out_load    = 1'b0;
    unique case (state)
      S_IDLE: begin
        pixel.ready = 1'b1;
        mem_re      = pixel.valid;
      end
      S_READ:  q_start = 1'b1;
      S_QUANT: ;
      S_WR_LEFT: begin
        mem_we    = (column_count != '0);
        mem_waddr = column_count - COL_W'(1);
        mem_wdata = wdata_left;
      end
      S_WR_HERE: mem_we = 1'b1;
      S_DONE:    out_load = out_free;
      default: ;
    endcase
  end

  edq_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (MEM_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (column_count),
    .rdata (mem_rdata)
  );

  // diffused sample: input + right carry + error from the row above
  always_comb begin
    for (int k = 0; k < N_CH; k++) begin
      vq[k] = V_W'($signed({1'b0, pix[k]})) + rc[k];
      if (!first_row) begin
        vq[k] = vq[k] + V_W'($signed(mem_rdata[k*ERR_W +: ERR_W]));
      end
    end
  end

  edq_quant u_quant (
    .clk   (clk),
    .rst   (rst),
    .start (q_start),
    .qp    (qp),
    .v     (vq),
    .done  (q_done),
    .q     (qo),
    .e     (eo)
  );

  // error shares and the sums for the row below
  always_comb begin
    for (int k = 0; k < N_CH; k++) begin
      s_right[k] = rhe16(PROD_W'(eo[k]) * PROD_W'(W_RIGHT));
      s_bl[k]    = rhe16(PROD_W'(eo[k]) * PROD_W'(W_BELOW_LEFT));
      s_below[k] = rhe16(PROD_W'(eo[k]) * PROD_W'(W_BELOW));
      s_br[k]    = rhe16(PROD_W'(eo[k]) * PROD_W'(W_BELOW_RIGHT));
      wdata_left[k*ERR_W +: ERR_W] = sat_err(sum_t'(bp0[k]) + sum_t'(s_bl[k]));
      wdata_here[k*ERR_W +: ERR_W] = sat_err(sum_t'(bp1[k]) + sum_t'(s_below[k]));
      bp0_next[k] = sat_err(sum_t'(bp1[k]) + sum_t'(s_below[k]));
      bp1_next[k] = sat_err(sum_t'(s_br[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix[0]     <= pixel.blue_in;
      pix[1]     <= pixel.green_in;
      pix[2]     <= pixel.red_in;
      last_frame <= pixel.last_in_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      first_row    <= 1'b1;
      for (int k = 0; k < N_CH; k++) begin
        rc[k]  <= '0;
        bp0[k] <= '0;
        bp1[k] <= '0;
      end
    end else if (out_load) begin
      if (last_frame) begin
        column_count <= '0;
        first_row    <= 1'b1;
      end else if (last_col) begin
        column_count <= '0;
        first_row    <= 1'b0;
      end else begin
        column_count <= column_count + COL_W'(1);
      end
      for (int k = 0; k < N_CH; k++) begin
        if (last_frame || last_col) begin
          rc[k]  <= '0;
          bp0[k] <= '0;
          bp1[k] <= '0;
        end else begin
          rc[k]  <= s_right[k];
          bp0[k] <= bp0_next[k];
          bp1[k] <= bp1_next[k];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.blue_out  <= qo[0];
      result.green_out <= qo[1];
      result.red_out   <= qo[2];
    end
  end

  assign result.valid = out_valid;
endmodule

@@ src/edq_checker.sv @@
// Port-level checks for the error diffusion quantizer, bound to the top level.
// Depends on edq_pkg and the assertion macro header.
`include "error_diffusion_dither_quantizer_unit_defines.svh"

module edq_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input edq_pkg::pix_t out_blue,
  input edq_pkg::pix_t out_green,
  input edq_pkg::pix_t out_red
);
  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  `EDQ_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, out_valid)
  `EDQ_ASSERT_NEXT(a_out_stable, clk, rst, out_stall, $stable(out_blue) && $stable(out_green) && $stable(out_red))
  // one pixel in flight: no second transaction right behind the first
  `EDQ_ASSERT_NEXT(a_one_in_flight, clk, rst, in_acc, !in_ready)
  // a result never appears on the edge right after a pixel is taken
  `EDQ_ASSERT_SAME(a_result_latency, clk, rst, $rose(out_valid), !$past(in_acc))
endmodule

bind error_diffusion_dither_quantizer_unit edq_checker u_edq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixel.valid),
  .in_ready  (pixel.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_blue  (result.blue_out),
  .out_green (result.green_out),
  .out_red   (result.red_out)
);
